// ----- hw/rtl/zaa_pkg.sv -----
// Package for the zoned append allocator: sizes, request and status codes,
// sequencer states and the zone table entry layout. No dependencies.
package zaa_pkg;

  localparam int ZONE_TOTAL = 1024;
  localparam int ZONE_BITS = $clog2(ZONE_TOTAL);
  localparam int ZB_SHIFT = 16;
  localparam int PTR_W = ZB_SHIFT + 1;
  localparam logic [PTR_W-1:0] ZONE_BLOCKS = PTR_W'(1) << ZB_SHIFT;
  localparam logic [26:0] FREE_MAX = '1;

  typedef enum logic [2:0] {
    REQ_ALLOC   = 3'd0,
    REQ_RELEASE = 3'd1,
    REQ_PICK    = 3'd2,
    REQ_RESET   = 3'd3,
    REQ_LOAD    = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_NO_CAND  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_FIRST_SEQ = 2'd0,
    CFG_ZONES     = 2'd1,
    CFG_CLEANING  = 2'd2,
    CFG_LOW_THR   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC,
    ST_REL,
    ST_PICK,
    ST_PICK_FIN,
    ST_RMW,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [PTR_W-1:0] wp;
    logic [PTR_W-1:0] dead;
  } zent_t;

endpackage

// ----- hw/rtl/zoned_append_allocator.sv -----
// Zoned append allocator top level: zone table memory and request sequencer.
// Depends on zaa_pkg.
//
// One request is handled at a time. Allocate and pick read one zone entry
// per cycle from the zone table (one synchronous memory holding the write
// pointer and dead count of every zone), scanning the sequential zones;
// release reads and updates each zone the extent covers; reset and load
// zone read and rewrite a single entry, and finish without touching the
// table when the zone is outside the sequential range. After reset a
// clearing pass over all 1024 entries fills the table before the first
// request is taken; configuration writes are accepted throughout.
// A finished result sits in an output register, and the next request may be
// taken while it waits.
module zoned_append_allocator
  import zaa_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // length_blocks[26:0], start_block[52:27], zone_index[62:53],
  // loaded_pointer[79:63], min_score_q[95:80], min_saved_blocks[112:96]
  input  logic [119:0] s_axis_tdata,
  // req_type[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // granted_block[25:0], chosen_zone[35:26], free_total[62:36], space_low[63]
  output logic [63:0]  m_axis_tdata,
  // status[1:0]
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [10:0]  cfg_data
);

  state_t state, state_next;

  // Configuration.
  logic [9:0]  first_seq_zone;
  logic [10:0] zones_in_use;
  logic [10:0] skip_zone;
  logic [8:0]  low_space_threshold;

  logic [10:0] next_zone;
  logic [26:0] free_count;

  // Captured request.
  logic [2:0]       req;
  logic [26:0]      len;
  logic [25:0]      sblk;
  logic [9:0]       zidx;
  logic [PTR_W-1:0] lptr;
  logic [15:0]      minq;
  logic [PTR_W-1:0] minsaved;

  // Scan control.
  logic [10:0]      iss_z;
  logic [10:0]      iss_left;
  logic             iss_on;
  logic             rd_vld;
  logic             rd_last;
  logic [9:0]       rd_z;
  logic [26:0]      plen;
  logic [PTR_W-1:0] chunk;
  logic [10:0]      clr_idx;

  // Pick tracking.
  logic             have;
  logic [9:0]       best_z;
  logic [PTR_W-1:0] best_d;
  logic [PTR_W:0]   best_l1;

  // Result.
  status_t     res_status;
  logic [25:0] res_granted;
  logic [9:0]  res_chosen;

  // Zone table.
  zent_t zmem [ZONE_TOTAL];
  zent_t rd_data;
  zent_t mem_wdata;
  logic  mem_we, mem_re;
  logic [ZONE_BITS-1:0] mem_waddr, mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      zmem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= zmem[mem_raddr];
    end
  end

  // Derived configuration values.
  logic [10:0] nz;
  logic        has_seq;
  logic [10:0] seq_cnt;
  logic [10:0] start_z;
  assign nz = (zones_in_use > 11'(ZONE_TOTAL)) ? 11'(ZONE_TOTAL) : zones_in_use;
  assign has_seq = {1'b0, first_seq_zone} < nz;
  assign seq_cnt = has_seq ? (nz - {1'b0, first_seq_zone}) : 11'd0;
  assign start_z = (next_zone < {1'b0, first_seq_zone} || next_zone >= nz) ?
                   {1'b0, first_seq_zone} : next_zone;

  logic accept;
  assign s_axis_tready = (state == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  // Entry arithmetic on the data just read.
  logic [PTR_W-1:0] e_wp, e_dead, e_live, e_room, e_wp_new, e_dead_new, ld_p;
  logic [PTR_W:0]   e_l1, d_sum;
  logic [26:0]      plen_new;
  logic             fit;
  logic             better;
  logic [2*PTR_W:0] prod_a, prod_b;
  logic [33:0]      fin_a, fin_b;
  logic [27:0]      f_add, f1;
  logic [26:0]      f2;
  logic [19:0]      thr_prod;
  logic             low;
  logic             out_free;

  always_comb begin
    e_wp = rd_data.wp;
    e_dead = rd_data.dead;
    e_live = (e_wp > e_dead) ? (e_wp - e_dead) : '0;
    e_l1 = {1'b0, e_live} + 1'b1;
    e_room = ZONE_BLOCKS - e_wp;
    fit = ({1'b0, rd_z} != skip_zone) && (len <= 27'(e_room));
    e_wp_new = e_wp + len[PTR_W-1:0];
    d_sum = {1'b0, e_dead} + {1'b0, chunk};
    e_dead_new = (d_sum > {1'b0, ZONE_BLOCKS}) ? ZONE_BLOCKS : d_sum[PTR_W-1:0];
    plen_new = plen - 27'(chunk);
    prod_a = 35'(e_dead) * 35'(best_l1);
    prod_b = 35'(best_d) * 35'(e_l1);
    better = !have || (prod_a > prod_b);
    fin_a = {best_d, 8'd0} + 34'd0;
    fin_b = 34'(minq) * 34'(best_l1);
    ld_p = (lptr > ZONE_BLOCKS) ? ZONE_BLOCKS : lptr;
    f_add = {1'b0, free_count} + 28'(e_wp);
    f1 = (f_add > {1'b0, FREE_MAX}) ? {1'b0, FREE_MAX} : f_add;
    f2 = (f1 > 28'(ld_p)) ? 27'(f1 - 28'(ld_p)) : 27'd0;
    thr_prod = 20'(low_space_threshold) * 20'(seq_cnt);
    low = {1'b0, free_count} <= {thr_prod, 8'd0};
    out_free = !m_axis_tvalid || m_axis_tready;
  end

  // Next state and memory port control.
  always_comb begin
    state_next = state;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_waddr = rd_z;
    mem_raddr = iss_z[ZONE_BITS-1:0];
    mem_wdata = rd_data;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_idx[ZONE_BITS-1:0];
        mem_wdata.wp = ZONE_BLOCKS;
        mem_wdata.dead = '0;
        if (clr_idx == 11'(ZONE_TOTAL - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            REQ_ALLOC:   state_next = has_seq ? ST_ALLOC : ST_FIN;
            REQ_RELEASE: state_next = (s_axis_tdata[26:0] != 27'd0) ? ST_REL : ST_FIN;
            REQ_PICK:    state_next = has_seq ? ST_PICK : ST_FIN;
            REQ_RESET,
            REQ_LOAD:    state_next = ST_RMW;
            default:     state_next = ST_FIN;
          endcase
        end
      end
      ST_ALLOC: begin
        mem_re = iss_on;
        if (rd_vld) begin
          if (fit) begin
            mem_we = 1'b1;
            mem_wdata.wp = e_wp_new;
            state_next = ST_FIN;
          end else if (rd_last) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_REL: begin
        mem_re = iss_on;
        if (rd_vld) begin
          mem_we = 1'b1;
          mem_wdata.dead = e_dead_new;
          if (plen_new == 27'd0 || rd_last) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_PICK: begin
        mem_re = iss_on;
        if (rd_vld && rd_last) begin
          state_next = ST_PICK_FIN;
        end
      end
      ST_PICK_FIN: state_next = ST_FIN;
      ST_RMW: begin
        mem_raddr = zidx;
        if (!rd_vld) begin
          if ({1'b0, zidx} >= {1'b0, first_seq_zone} && {1'b0, zidx} < nz) begin
            mem_re = 1'b1;
          end else begin
            state_next = ST_FIN;
          end
        end else begin
          mem_we = 1'b1;
          mem_waddr = zidx;
          mem_wdata.wp = (req == REQ_LOAD) ? ld_p : '0;
          mem_wdata.dead = '0;
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control and bookkeeping registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_seq_zone <= '0;
      zones_in_use <= 11'(ZONE_TOTAL);
      skip_zone <= 11'(ZONE_TOTAL);
      low_space_threshold <= 9'd64;
      next_zone <= '0;
      free_count <= '0;
      clr_idx <= '0;
      iss_on <= 1'b0;
      rd_vld <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end

      // Scan issue side; the read result follows in the next cycle.
      if (state == ST_ALLOC || state == ST_PICK || state == ST_REL) begin
        rd_vld <= iss_on && (state_next == state);
        rd_z <= iss_z[ZONE_BITS-1:0];
        if (iss_on) begin
          iss_left <= iss_left - 1'b1;
          if (state == ST_ALLOC && iss_z + 1'b1 >= nz) begin
            iss_z <= {1'b0, first_seq_zone};
          end else begin
            iss_z <= iss_z + 1'b1;
          end
          if (state == ST_REL) begin
            rd_last <= (iss_z == 11'(ZONE_TOTAL - 1));
          end else begin
            rd_last <= (iss_left == 11'd1);
          end
        end
        if (state_next != state) begin
          iss_on <= 1'b0;
        end else if (iss_on) begin
          iss_on <= (state == ST_REL) ? (iss_z != 11'(ZONE_TOTAL - 1))
                                      : (iss_left != 11'd1);
        end
      end else if (state == ST_RMW) begin
        rd_vld <= !rd_vld && mem_re;
      end else begin
        rd_vld <= 1'b0;
      end

      if (accept) begin
        iss_on <= 1'b1;
        have <= 1'b0;
        plen <= s_axis_tdata[26:0];
        case (s_axis_tuser)
          REQ_ALLOC: begin
            iss_z <= start_z;
            iss_left <= seq_cnt;
          end
          REQ_RELEASE: begin
            iss_z <= {1'b0, s_axis_tdata[52:43]};
            chunk <= (27'(ZONE_BLOCKS - {1'b0, s_axis_tdata[42:27]}) > s_axis_tdata[26:0]) ?
                     s_axis_tdata[PTR_W-1:0] : (ZONE_BLOCKS - {1'b0, s_axis_tdata[42:27]});
          end
          default: begin
            iss_z <= {1'b0, first_seq_zone};
            iss_left <= seq_cnt;
          end
        endcase
      end

      if (state == ST_ALLOC && rd_vld && fit) begin
        free_count <= (free_count > len) ? (free_count - len) : 27'd0;
        if (e_wp_new[PTR_W-1]) begin
          next_zone <= {1'b0, rd_z} + 1'b1;
        end
      end

      if (state == ST_REL && rd_vld) begin
        plen <= plen_new;
        chunk <= (plen_new >= 27'(ZONE_BLOCKS)) ? ZONE_BLOCKS : plen_new[PTR_W-1:0];
      end

      if (state == ST_PICK && rd_vld && e_dead >= minsaved && better) begin
        have <= 1'b1;
        best_z <= rd_z;
        best_d <= e_dead;
        best_l1 <= e_l1;
      end

      if (state == ST_RMW && rd_vld) begin
        free_count <= (req == REQ_LOAD) ? f2 : f1[26:0];
      end

      if (state == ST_FIN && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      // The user keeps configuration writes to when no request is in progress; not enforced here.
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FIRST_SEQ: begin
            first_seq_zone <= cfg_data[9:0];
            next_zone <= {1'b0, cfg_data[9:0]};
          end
          CFG_ZONES:    zones_in_use <= cfg_data;
          CFG_CLEANING: skip_zone <= cfg_data;
          CFG_LOW_THR:  low_space_threshold <= cfg_data[8:0];
          default:      ;
        endcase
      end
    end
  end

  // Request capture and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= s_axis_tuser;
      len <= s_axis_tdata[26:0];
      sblk <= s_axis_tdata[52:27];
      zidx <= s_axis_tdata[62:53];
      lptr <= s_axis_tdata[79:63];
      minq <= s_axis_tdata[95:80];
      minsaved <= s_axis_tdata[112:96];
      res_granted <= '0;
      res_chosen <= '0;
      case (s_axis_tuser)
        REQ_ALLOC: res_status <= has_seq ? STAT_DONE : STAT_NO_SPACE;
        REQ_PICK:  res_status <= has_seq ? STAT_DONE : STAT_NO_CAND;
        default:   res_status <= STAT_DONE;
      endcase
    end
    if (state == ST_ALLOC && rd_vld) begin
      if (fit) begin
        res_granted <= 26'({rd_z, 16'd0} + 26'(e_wp));
        res_chosen <= rd_z;
      end else if (rd_last) begin
        res_status <= STAT_NO_SPACE;
      end
    end
    if (state == ST_PICK_FIN) begin
      if (have && fin_a >= fin_b) begin
        res_chosen <= best_z;
      end else begin
        res_status <= STAT_NO_CAND;
      end
    end
    if (state == ST_FIN && out_free) begin
      m_axis_tdata <= {low, free_count, res_chosen, res_granted};
      m_axis_tuser <= res_status;
    end
  end

  logic unused_ok;
  assign unused_ok = ^{sblk, s_axis_tdata[119:113]};

endmodule

// ----- hw/rtl/zaa_checker.sv -----
// Port-level checker for the zoned append allocator, bound to the top level.
// Depends on zaa_pkg.
module zaa_props
  import zaa_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // The table clearing pass holds off requests right after reset.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("request taken during table clear");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_no_space_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == STAT_NO_SPACE |-> m_axis_tdata[35:0] == 36'd0)
    else $error("failed allocate carries a grant");

  a_no_cand_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == STAT_NO_CAND |-> m_axis_tdata[35:0] == 36'd0)
    else $error("failed pick carries a zone");

  a_empty_is_low: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[62:36] == 27'd0 |-> m_axis_tdata[63])
    else $error("zero free space not flagged low");

endmodule

bind zoned_append_allocator zaa_props u_zaa_props (
  .clk(clk),
  .rst(rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata),
  .m_axis_tuser(m_axis_tuser)
);
